>>> design/mcse_pkg.sv
// ----------------------------------------------------------------------------
// mcse_pkg
// Shared codes, CRC constants and item/result types for the multi-CRC
// stream engine.
// ----------------------------------------------------------------------------
package mcse_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // Algorithm codes carried in alg_select.
  localparam logic [1:0] ALG_CRC8  = 2'd0;
  localparam logic [1:0] ALG_CRC16 = 2'd1;
  localparam logic [1:0] ALG_CRC32 = 2'd2;
  localparam logic [1:0] ALG_BAD   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ALG = 2'd1;
  localparam logic [1:0] ST_CLOSED  = 2'd2;

  // CRC-8 SAE J1850.
  localparam logic [7:0]  J1850_POLY     = 8'h1D;
  localparam logic [7:0]  J1850_SEED     = 8'hFF;
  localparam logic [7:0]  J1850_OUT_MASK = 8'hFF;
  // CRC-16 CCITT-FALSE.
  localparam logic [15:0] CCITT_POLY     = 16'h1021;
  localparam logic [15:0] CCITT_SEED     = 16'hFFFF;
  localparam logic [15:0] CCITT_OUT_MASK = 16'h0000;
  // CRC-32 Ethernet, reflected. The reflected polynomial is the normal one
  // with its 32 bits reversed.
  localparam logic [31:0] ETH_POLY     = 32'h04C11DB7;
  localparam logic [31:0] ETH_POLY_REV = 32'hEDB88320;
  localparam logic [31:0] ETH_SEED     = 32'hFFFFFFFF;
  localparam logic [31:0] ETH_OUT_MASK = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] alg_select;
    logic [7:0] data_byte;
  } mcse_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] crc_value;
  } mcse_result_t;

endpackage

>>> design/mcse_fold.sv
// ----------------------------------------------------------------------------
// mcse_fold
// Byte-wide combinational CRC update for the three supported algorithms.
// ----------------------------------------------------------------------------
module mcse_fold (
  input  logic [31:0] acc,
  input  logic [1:0]  alg,
  input  logic [7:0]  data_byte,
  output logic [31:0] acc_nxt
);
  import mcse_pkg::*;

  function automatic logic [7:0] fold8(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ J1850_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] fold16(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Reflected form: the register shifts right and the byte enters at the LSB.
  function automatic logic [31:0] fold32(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ ETH_POLY_REV) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  always_comb begin
    unique case (alg)
      ALG_CRC8:  acc_nxt = {24'h000000, fold8(acc[7:0], data_byte)};
      ALG_CRC16: acc_nxt = {16'h0000, fold16(acc[15:0], data_byte)};
      default:   acc_nxt = fold32(acc, data_byte);
    endcase
  end

endmodule

>>> design/mcse_core.sv
// ----------------------------------------------------------------------------
// mcse_core
// Stream state (accumulator, active algorithm, closed flag) and the
// request decode that forms one result per item.
// ----------------------------------------------------------------------------
module mcse_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_go,
  input  mcse_pkg::mcse_item_t  item,
  output mcse_pkg::mcse_result_t result
);
  import mcse_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  alg_r, alg_nxt;
  logic        closed_r, closed_nxt;
  logic [31:0] fold_acc;

  mcse_fold u_fold (
    .acc       (acc_r),
    .alg       (alg_r),
    .data_byte (item.data_byte),
    .acc_nxt   (fold_acc)
  );

  always_comb begin
    acc_nxt          = acc_r;
    alg_nxt          = alg_r;
    closed_nxt       = closed_r;
    result.status    = ST_OK;
    result.crc_value = 32'h00000000;
    unique case (item.req_type)
      REQ_START: begin
        unique case (item.alg_select)
          ALG_CRC8:  acc_nxt = {24'h000000, J1850_SEED};
          ALG_CRC16: acc_nxt = {16'h0000, CCITT_SEED};
          ALG_CRC32: acc_nxt = ETH_SEED;
          ALG_BAD:   result.status = ST_BAD_ALG;
        endcase
        if (item.alg_select != ALG_BAD) begin
          alg_nxt    = item.alg_select;
          closed_nxt = 1'b0;
        end
      end
      REQ_DATA, REQ_FINISH: begin
        if (closed_r) begin
          result.status = ST_CLOSED;
        end else if (item.req_type == REQ_DATA) begin
          acc_nxt = fold_acc;
        end else begin
          unique case (alg_r)
            ALG_CRC8:  result.crc_value = {24'h000000, acc_r[7:0] ^ J1850_OUT_MASK};
            ALG_CRC16: result.crc_value = {16'h0000, acc_r[15:0] ^ CCITT_OUT_MASK};
            default:   result.crc_value = acc_r ^ ETH_OUT_MASK;
          endcase
          closed_nxt = 1'b1;
        end
      end
      default: begin
        // Unused request code: no effect on the stream.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 32'h00000000;
      alg_r    <= ALG_CRC8;
      closed_r <= 1'b1;
    end else if (item_go) begin
      acc_r    <= acc_nxt;
      alg_r    <= alg_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

>>> design/multi_crc_stream_engine_top.sv
// ----------------------------------------------------------------------------
// multi_crc_stream_engine_top
// Streaming CRC-8 / CRC-16 / CRC-32 engine with valid/stall channels.
// ----------------------------------------------------------------------------
// The engine takes one item per clock while in_stall is low and returns exactly
// one result per item, through the input register and then the result register.
// An accepted item lands in an input register; the byte-wide CRC fold and the
// request decode sit between that register and the result register, so the
// combinational fold of the accumulator is what sets the rate of one byte per
// clock. in_stall rises only while the input register holds an item and the
// result register is full and stalled; it follows out_stall in the same cycle.
module multi_crc_stream_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_alg_select,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_crc_value
);
  import mcse_pkg::*;

  logic         s1_vld_r;
  mcse_item_t   s1_item_r;
  logic         out_vld_r;
  mcse_result_t out_res_r;
  mcse_result_t core_res;
  logic         out_adv;
  logic         s1_fire;
  logic         in_fire;

  // The result register can load when it is empty or being taken.
  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_adv;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  mcse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (s1_fire),
    .item    (s1_item_r),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (out_adv) begin
        out_vld_r <= s1_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req_type   <= in_req_type;
      s1_item_r.alg_select <= in_alg_select;
      s1_item_r.data_byte  <= in_data_byte;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_res_r.status;
  assign out_crc_value = out_res_r.crc_value;

endmodule

>>> design/mcse_checker.sv
// ----------------------------------------------------------------------------
// mcse_checker
// Port-level checks for the multi-CRC stream engine, bound to the top level.
// ----------------------------------------------------------------------------
module mcse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic [1:0]  in_alg_select,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_crc_value
);
  import mcse_pkg::*;

  // The input side only backs up when a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A result with an error status never carries a CRC.
  a_err_zero_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_crc_value == 32'h00000000))
    else $error("error result with nonzero crc_value");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_ALG ||
                   out_status == ST_CLOSED))
    else $error("undefined status code");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_crc_value)))
    else $error("stalled result changed");

  // A stalled input item stays in place until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_req_type) && $stable(in_alg_select) &&
       $stable(in_data_byte)))
    else $error("stalled input item changed");

endmodule

bind multi_crc_stream_engine_top mcse_checker u_mcse_checker (.*);
